### design/isotp_pkg.sv
// ----------------------------------------------------------------------------
// isotp_pkg
// shared types and constants of the iso-tp receive reassembler
// ----------------------------------------------------------------------------
`default_nettype none

package isotp_pkg;

    // longest message a first frame may announce
    localparam int unsigned MAX_MESSAGE = 4095;

    localparam int unsigned IN_DATA_W  = 80;  // frame_id + byte0..byte7, padded
    localparam int unsigned OUT_DATA_W = 40;  // data_byte, position, cause, send_id, padded
    localparam int unsigned FRAME_BYTES = 8;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CTS   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ABORT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_SEQ        = 2'd1,
        CAUSE_TIMEOUT    = 2'd2,
        CAUSE_UNEXPECTED = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        CFG_RX_ID    = 2'd0,
        CFG_TX_ID    = 2'd1,
        CFG_CAPACITY = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    // protocol control nibble
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;

    localparam logic [3:0]  SF_MAX_LEN  = 4'd7;
    localparam logic [11:0] FF_MIN_LEN  = 12'd8;
    localparam logic [11:0] FF_BYTES    = 12'd6;
    localparam logic [2:0]  CF_MAX_DATA = 3'd7;
    localparam logic [3:0]  SEQ_FIRST   = 4'd1;

    localparam logic [10:0] RX_ID_RST    = 11'd2047;
    localparam logic [10:0] TX_ID_RST    = 11'd2047;
    localparam logic [11:0] CAPACITY_RST = 12'd4095;
    localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

endpackage

`default_nettype wire

### design/isotp_reassembler_rx.sv
// ----------------------------------------------------------------------------
// isotp_reassembler_rx
// iso-tp receive side: decodes single, first and consecutive frames and
// streams the payload bytes out with flow control, completion and abort items
// ----------------------------------------------------------------------------
// Each input item is decoded in the cycle it is accepted: the protocol state
// is updated at once and the results are parked in a small descriptor, from
// which one result per cycle, while the output register is free or being
// taken, is loaded into it. An item causes up to 8 results (a seven-byte
// single frame, or a consecutive frame that ends the message with seven
// bytes), 7 for a first frame; ticks, foreign ids and ignored frames cause
// none. The next item is taken in the same cycle as the last result of the
// previous one is loaded, so items follow each other without gaps while the
// output side keeps taking results.
`default_nettype none

module isotp_reassembler_rx
    import isotp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [15:0]           i_cfg_wdata,
    // input items
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // frame_id, byte0 .. byte7
    input  wire logic                  i_s_axis_tuser,   // opcode
    // result items
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // data_byte, position, abort_cause,
                                                         // send_id
    output logic [1:0]                 o_m_axis_tuser,   // kind
    output logic                       o_m_axis_tlast    // last
);

    // configuration
    logic [10:0] r_rx_id;
    logic [10:0] r_tx_id;
    logic [11:0] r_capacity;
    logic [15:0] r_timeout;

    // protocol state
    logic        r_assembling, n_assembling;
    logic [11:0] r_msg_len, n_msg_len;
    logic [11:0] r_rcvd, n_rcvd;
    logic [3:0]  r_seq, n_seq;
    logic [15:0] r_ticks, n_ticks;

    // result descriptor
    logic [3:0]  r_rem, n_rem;
    logic [2:0]  r_idx;
    logic [2:0]  r_nb, d_nb;
    logic [7:0]  r_data [FRAME_BYTES];
    logic [7:0]  d_data [FRAME_BYTES];
    logic [11:0] r_base, d_base;
    logic        d_tail;
    t_kind       r_tkind, d_tkind;
    logic [11:0] r_tpos, d_tpos;
    t_cause      r_tcause, d_tcause;
    logic [10:0] r_tsid, d_tsid;

    // output register
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_data;
    logic [11:0] r_out_pos;
    t_cause      r_out_cause;
    logic [10:0] r_out_sid;
    logic        r_out_last;

    logic        s_acc;
    logic        load;
    logic [10:0] w_id;
    logic [7:0]  w_b [FRAME_BYTES];
    logic [3:0]  w_pci;
    logic [3:0]  w_nib;
    logic [11:0] w_ff_len;
    logic [11:0] w_cf_rem;
    logic [2:0]  w_cf_nb;
    logic [11:0] w_cf_new;

    always_comb begin
        w_id = i_s_axis_tdata[10:0];
        for (int k = 0; k < FRAME_BYTES; k++) begin
            w_b[k] = i_s_axis_tdata[11 + 8*k +: 8];
        end
    end

    assign load            = (r_rem != 4'd0) && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = (r_rem == 4'd0) || ((r_rem == 4'd1) && load);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_pci    = w_b[0][7:4];
    assign w_nib    = w_b[0][3:0];
    assign w_ff_len = {w_nib, w_b[1]};
    assign w_cf_rem = (r_msg_len > r_rcvd) ? (r_msg_len - r_rcvd) : 12'd0;
    assign w_cf_nb  = (w_cf_rem > 12'(CF_MAX_DATA)) ? CF_MAX_DATA : w_cf_rem[2:0];
    assign w_cf_new = r_rcvd + 12'(w_cf_nb);

    // decode of one accepted item
    always_comb begin
        n_assembling = r_assembling;
        n_msg_len    = r_msg_len;
        n_rcvd       = r_rcvd;
        n_seq        = r_seq;
        n_ticks      = r_ticks;
        d_nb         = 3'd0;
        d_base       = 12'd0;
        d_tail       = 1'b0;
        d_tkind      = KIND_DONE;
        d_tpos       = 12'd0;
        d_tcause     = CAUSE_NONE;
        d_tsid       = 11'd0;
        for (int k = 0; k < FRAME_BYTES - 1; k++) begin
            d_data[k] = w_b[k+1];
        end
        d_data[FRAME_BYTES-1] = 8'd0;

        if (t_opcode'(i_s_axis_tuser) == OP_TICK) begin
            if (r_ticks != 16'hFFFF) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (w_id == r_rx_id) begin
            if (!r_assembling) begin
                if (w_pci == PCI_SF) begin
                    if (w_nib != 4'd0 && w_nib <= SF_MAX_LEN
                            && 12'(w_nib) <= r_capacity) begin
                        d_nb     = w_nib[2:0];
                        d_tail   = 1'b1;
                        d_tkind  = KIND_DONE;
                        d_tpos   = 12'(w_nib);
                    end
                end else if (w_pci == PCI_FF) begin
                    if (w_ff_len >= FF_MIN_LEN && 32'(w_ff_len) <= MAX_MESSAGE
                            && w_ff_len <= r_capacity) begin
                        for (int k = 0; k < FRAME_BYTES - 2; k++) begin
                            d_data[k] = w_b[k+2];
                        end
                        d_data[FRAME_BYTES-2] = 8'd0;
                        d_nb         = 3'(FF_BYTES);
                        d_tail       = 1'b1;
                        d_tkind      = KIND_CTS;
                        d_tsid       = r_tx_id;
                        n_msg_len    = w_ff_len;
                        n_rcvd       = FF_BYTES;
                        n_seq        = SEQ_FIRST;
                        n_assembling = 1'b1;
                        n_ticks      = 16'd0;
                    end
                end
            end else begin
                d_tail = 1'b1;
                priority if (r_ticks > r_timeout) begin
                    n_assembling = 1'b0;
                    d_tkind      = KIND_ABORT;
                    d_tcause     = CAUSE_TIMEOUT;
                end else if (w_pci != PCI_CF) begin
                    n_assembling = 1'b0;
                    d_tkind      = KIND_ABORT;
                    d_tcause     = CAUSE_UNEXPECTED;
                end else if (w_nib != r_seq) begin
                    n_assembling = 1'b0;
                    d_tkind      = KIND_ABORT;
                    d_tcause     = CAUSE_SEQ;
                end else begin
                    d_nb    = w_cf_nb;
                    d_base  = r_rcvd;
                    n_rcvd  = w_cf_new;
                    n_seq   = r_seq + 4'd1;
                    n_ticks = 16'd0;
                    // completion only when the message is full
                    d_tail  = (w_cf_new >= r_msg_len);
                    d_tkind = KIND_DONE;
                    d_tpos  = r_msg_len;
                    if (w_cf_new >= r_msg_len) begin
                        n_assembling = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        n_rem = r_rem;
        if (load) begin
            n_rem = r_rem - 4'd1;
        end
        if (s_acc) begin
            n_rem = 4'(d_nb) + 4'(d_tail);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_id    <= RX_ID_RST;
            r_tx_id    <= TX_ID_RST;
            r_capacity <= CAPACITY_RST;
            r_timeout  <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RX_ID:    r_rx_id    <= i_cfg_wdata[10:0];
                CFG_TX_ID:    r_tx_id    <= i_cfg_wdata[10:0];
                CFG_CAPACITY: r_capacity <= i_cfg_wdata[11:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assembling <= 1'b0;
            r_msg_len    <= 12'd0;
            r_rcvd       <= 12'd0;
            r_seq        <= SEQ_FIRST;
            r_ticks      <= 16'd0;
            r_rem        <= 4'd0;
            r_idx        <= 3'd0;
        end else begin
            r_rem <= n_rem;
            if (s_acc) begin
                r_assembling <= n_assembling;
                r_msg_len    <= n_msg_len;
                r_rcvd       <= n_rcvd;
                r_seq        <= n_seq;
                r_ticks      <= n_ticks;
                r_idx        <= 3'd0;
            end else if (load) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_nb     <= d_nb;
            r_data   <= d_data;
            r_base   <= d_base;
            r_tkind  <= d_tkind;
            r_tpos   <= d_tpos;
            r_tcause <= d_tcause;
            r_tsid   <= d_tsid;
        end
    end

    // output register, one result per cycle from the descriptor while it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_last <= (r_rem == 4'd1);
            if (r_idx < r_nb) begin
                r_out_kind  <= KIND_BYTE;
                r_out_data  <= r_data[r_idx];
                r_out_pos   <= r_base + 12'(r_idx);
                r_out_cause <= CAUSE_NONE;
                r_out_sid   <= 11'd0;
            end else begin
                r_out_kind  <= r_tkind;
                r_out_data  <= 8'd0;
                r_out_pos   <= r_tpos;
                r_out_cause <= r_tcause;
                r_out_sid   <= r_tsid;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_sid, r_out_cause, r_out_pos, r_out_data};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### design/isotp_checker.sv
// ----------------------------------------------------------------------------
// isotp_checker
// port-level checks of the iso-tp receive reassembler, bound to its top level
// ----------------------------------------------------------------------------
`default_nettype none

module isotp_checker
    import isotp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [1:0]            o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // abort and flow control always close the results of their item
    a_abort_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_ABORT || o_m_axis_tuser == KIND_CTS)
            |-> o_m_axis_tlast)
        else $error("abort or cts not last");

    // a cause is given exactly on aborts
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tuser == KIND_ABORT) == (o_m_axis_tdata[21:20] != CAUSE_NONE)))
        else $error("abort cause mismatch");

    // completion is last and reports a nonzero length
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_DONE |->
            o_m_axis_tlast && o_m_axis_tdata[19:8] != 12'd0)
        else $error("bad completion item");

endmodule

bind isotp_reassembler_rx isotp_checker u_isotp_checker (.*);

`default_nettype wire
